>>> design/etl_pkg.sv
package etl_pkg;

	// Request codes carried on req_type.
	typedef enum logic [2:0] {
		REQ_START = 3'd0,
		REQ_STOP  = 3'd1,
		REQ_EDGE  = 3'd2,
		REQ_TICK  = 3'd3,
		REQ_SWAP  = 3'd4,
		REQ_READ  = 3'd5
	} req_t;

	// Row address width that covers the largest supported bank size.
	localparam int ADDR_W = 12;

	// Level marks ORed into the 14-bit timer value of an edge word.
	localparam logic [15:0] MARK_HIGH = 16'h4000;
	localparam logic [15:0] MARK_LOW  = 16'h8000;

	// A run byte below or at this value can still be incremented in place.
	localparam logic [5:0] RUN_LIMIT = 6'd62;

	// One write port of a byte memory.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] row;
		logic [7:0]        data;
	} mem_wr_t;

	// Result fields that are settled when the request is classified.
	typedef struct packed {
		logic        accepted;
		logic        dropped;
		logic        bank;
		logic [9:0]  frozen_len;
		logic [15:0] edge_count;
	} res_t;

	// Command handed from the front to the back.
	typedef struct packed {
		mem_wr_t           wr_even;
		mem_wr_t           wr_odd;
		logic              rd_en;
		logic              rd_odd;
		logic [ADDR_W-1:0] rd_row;
		res_t              res;
	} cmd_t;

	// Completed result beat.
	typedef struct packed {
		res_t       res;
		logic [7:0] byte_data;
	} out_t;

endpackage

>>> design/etl_fifo.sv
module etl_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2,
	localparam int LVW = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  T               wdata,
	output logic           full,
	input  logic           pop,
	output T               rdata,
	output logic           empty,
	output logic [LVW-1:0] level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T              slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LVW-1:0] count_q;

	// Status flags and head of the queue.
	assign full  = (count_q == LVW'(DEPTH));
	assign empty = (count_q == '0);
	assign level = count_q;
	assign rdata = slots_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

>>> design/etl_front.sv
module etl_front #(
	parameter int BANK_BYTES = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [2:0]     req_type,
	input  logic           pin_level,
	input  logic [13:0]    timer_count,
	input  logic [8:0]     byte_index,
	output etl_pkg::cmd_t  cmd
);
	import etl_pkg::*;

	localparam int FW   = $clog2(BANK_BYTES + 1);
	localparam int FW1  = FW + 1;
	localparam int HALF = (BANK_BYTES + 1) / 2;
	localparam int CW   = (FW > 9) ? FW : 9;
	localparam int LW   = (FW > 10) ? FW : 10;

	logic [FW-1:0] fill_a_q, fill_b_q;
	logic          active_q;
	logic          run_open_q;
	logic [5:0]    last_run_q;
	logic          logging_q;
	logic [15:0]   high_edges_q;

	logic [FW-1:0] fill_a_d, fill_b_d;
	logic          active_d;
	logic          run_open_d;
	logic [5:0]    last_run_d;
	logic          logging_d;
	logic [15:0]   high_edges_d;

	logic [FW-1:0] fp, ofill, fp_inc;
	logic [FW-1:0] pos;
	logic [LW-1:0] flen_ext;
	logic [15:0]   word;
	logic [7:0]    byte_val;
	logic          room_two;

	// Row of a byte in the parity-split memories.
	function automatic logic [ADDR_W-1:0] row_of(input logic bank, input logic [CW-1:0] p);
		logic [ADDR_W-1:0] base;
		base = bank ? ADDR_W'(HALF) : '0;
		return base + ADDR_W'(p >> 1);
	endfunction

	// Fill of the bank being written and of the handed-over bank.
	assign fp       = active_q ? fill_b_q : fill_a_q;
	assign ofill    = active_q ? fill_a_q : fill_b_q;
	assign fp_inc   = fp + 1'b1;
	assign flen_ext = LW'(fp);
	assign word     = {2'b00, timer_count} | (pin_level ? MARK_HIGH : MARK_LOW);
	assign room_two = ({1'b0, fp} + FW1'(2)) <= FW1'(BANK_BYTES);

	// Classify the request, compute the next state and the memory command.
	always_comb begin
		fill_a_d     = fill_a_q;
		fill_b_d     = fill_b_q;
		active_d     = active_q;
		run_open_d   = run_open_q;
		last_run_d   = last_run_q;
		logging_d    = logging_q;
		high_edges_d = high_edges_q;
		pos          = fp;
		byte_val     = 8'd1;
		cmd          = '0;
		case (req_t'(req_type))
			REQ_START: begin
				fill_a_d     = '0;
				fill_b_d     = '0;
				active_d     = 1'b0;
				run_open_d   = 1'b0;
				last_run_d   = '0;
				high_edges_d = '0;
				logging_d    = 1'b1;
				cmd.res.accepted = 1'b1;
			end
			REQ_STOP: begin
				logging_d = 1'b0;
				cmd.res.accepted = 1'b1;
			end
			REQ_EDGE: begin
				if (logging_q) begin
					if (room_two) begin
						// The two bytes always land in different parity memories.
						if (!fp[0]) begin
							cmd.wr_even = '{en: 1'b1, row: row_of(active_q, CW'(fp)),
								data: word[15:8]};
							cmd.wr_odd  = '{en: 1'b1, row: row_of(active_q, CW'(fp)),
								data: word[7:0]};
						end else begin
							cmd.wr_odd  = '{en: 1'b1, row: row_of(active_q, CW'(fp)),
								data: word[15:8]};
							cmd.wr_even = '{en: 1'b1, row: row_of(active_q, CW'(fp_inc)),
								data: word[7:0]};
						end
						if (active_q) begin
							fill_b_d = fp + FW'(2);
						end else begin
							fill_a_d = fp + FW'(2);
						end
						run_open_d = 1'b0;
						cmd.res.accepted = 1'b1;
					end else begin
						cmd.res.dropped = 1'b1;
					end
					if (pin_level) begin
						high_edges_d = high_edges_q + 1'b1;
					end
				end
			end
			REQ_TICK: begin
				if (logging_q) begin
					if (run_open_q && (last_run_q <= RUN_LIMIT) && (fp != '0)) begin
						// Bump the open run byte in place from its shadow.
						last_run_d = last_run_q + 1'b1;
						pos        = fp - 1'b1;
						byte_val   = {2'b00, last_run_d};
						cmd.res.accepted = 1'b1;
					end else if (fp < FW'(BANK_BYTES)) begin
						pos        = fp;
						byte_val   = 8'd1;
						run_open_d = 1'b1;
						last_run_d = 6'd1;
						if (active_q) begin
							fill_b_d = fp_inc;
						end else begin
							fill_a_d = fp_inc;
						end
						cmd.res.accepted = 1'b1;
					end else begin
						cmd.res.dropped = 1'b1;
					end
					if (cmd.res.accepted) begin
						if (pos[0]) begin
							cmd.wr_odd  = '{en: 1'b1, row: row_of(active_q, CW'(pos)),
								data: byte_val};
						end else begin
							cmd.wr_even = '{en: 1'b1, row: row_of(active_q, CW'(pos)),
								data: byte_val};
						end
					end
				end
			end
			REQ_SWAP: begin
				if (fp != '0) begin
					cmd.res.bank       = active_q;
					cmd.res.frozen_len = flen_ext[9:0];
					active_d           = ~active_q;
					if (active_q) begin
						fill_a_d = '0;
					end else begin
						fill_b_d = '0;
					end
					run_open_d = 1'b0;
					cmd.res.accepted = 1'b1;
				end
			end
			REQ_READ: begin
				if (CW'(byte_index) < CW'(ofill)) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_odd = byte_index[0];
					cmd.rd_row = row_of(~active_q, CW'(byte_index));
					cmd.res.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		cmd.res.edge_count = high_edges_d;
	end

	// Logger state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_a_q     <= '0;
			fill_b_q     <= '0;
			active_q     <= 1'b0;
			run_open_q   <= 1'b0;
			last_run_q   <= '0;
			logging_q    <= 1'b0;
			high_edges_q <= '0;
		end else if (take) begin
			fill_a_q     <= fill_a_d;
			fill_b_q     <= fill_b_d;
			active_q     <= active_d;
			run_open_q   <= run_open_d;
			last_run_q   <= last_run_d;
			logging_q    <= logging_d;
			high_edges_q <= high_edges_d;
		end
	end

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && req_type == REQ_START) |=>
			(logging_q && fill_a_q == '0 && fill_b_q == '0 && high_edges_q == '0))
		else $error("start did not clear the logger state");

	a_run_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> (fp != '0 && last_run_q != '0))
		else $error("open run without a run byte in the active bank");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_a_q <= FW'(BANK_BYTES)) && (fill_b_q <= FW'(BANK_BYTES)))
		else $error("bank fill beyond bank size");

endmodule

>>> design/etl_back.sv
module etl_back #(
	parameter int BANK_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  etl_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output etl_pkg::out_t result
);
	import etl_pkg::*;

	localparam int HALF      = (BANK_BYTES + 1) / 2;
	localparam int ROWS      = 2 * HALF;
	localparam int AW        = $clog2(ROWS);
	localparam int OUT_DEPTH = 3;
	localparam int OLW       = $clog2(OUT_DEPTH + 1);

	logic [7:0] mem_even [ROWS];
	logic [7:0] mem_odd  [ROWS];

	logic       even_rd_q, odd_rd_q;
	logic [7:0] even_q, odd_q;
	logic       s1_valid_q;
	res_t       res_s1;
	logic       rd_s1;
	logic       rd_odd_s1;

	logic [OLW-1:0] out_level;
	logic           out_full;
	out_t           out_beat;

	// Issue a command only when the result queue has a slot for it.
	assign cmd_pop = !cmd_empty &&
		(({1'b0, out_level} + (OLW + 1)'(s1_valid_q)) < (OLW + 1)'(OUT_DEPTH));

	// Byte memories, one per byte parity; read data is registered.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.wr_even.en) begin
			mem_even[cmd.wr_even.row[AW-1:0]] <= cmd.wr_even.data;
		end
		if (cmd_pop && cmd.wr_odd.en) begin
			mem_odd[cmd.wr_odd.row[AW-1:0]] <= cmd.wr_odd.data;
		end
		if (cmd_pop && cmd.rd_en) begin
			even_q <= mem_even[cmd.rd_row[AW-1:0]];
			odd_q  <= mem_odd[cmd.rd_row[AW-1:0]];
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_s1    <= cmd.res;
			rd_s1     <= cmd.rd_en;
			rd_odd_s1 <= cmd.rd_odd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= cmd_pop;
		end
	end

	// Assemble the result beat; a read that was refused returns zero.
	always_comb begin
		out_beat.res       = res_s1;
		out_beat.byte_data = rd_s1 ? (rd_odd_s1 ? odd_q : even_q) : 8'd0;
	end

	etl_fifo #(
		.T     (out_t),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s1_valid_q),
		.wdata  (out_beat),
		.full   (out_full),
		.pop    (pop && !empty),
		.rdata  (result),
		.empty  (empty),
		.level  (out_level)
	);

	a_slot_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> !out_full)
		else $error("result arrived with no reserved slot");

endmodule

>>> design/edge_timestamp_pingpong_logger_top.sv
// Channel   Handshake          Beat contents
// -------   ----------------   ---------------------------------------------------
// request   push / full        req_type, pin_level, timer_count, byte_index
// result    pop / empty        accepted, dropped, bank, frozen_len, byte_data,
//                              edge_count
//
// One request beat is taken every cycle while full is low; each request gives one
// result beat. A request passes through the request queue, the byte memory access
// and the result queue on its way to its result. The request and result sides stall
// on their own through a two-entry request queue and a three-entry result queue.
// arst_n clears all logger state and empties both queues; the byte memories hold
// no reset and are only read where the bank fill says they were written.
module edge_timestamp_pingpong_logger_top #(
	parameter int BANK_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic        pin_level,
	input  logic [13:0] timer_count,
	input  logic [8:0]  byte_index,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic        dropped,
	output logic        bank,
	output logic [9:0]  frozen_len,
	output logic [7:0]  byte_data,
	output logic [15:0] edge_count
);
	import etl_pkg::*;

	logic  take;
	cmd_t  front_cmd;
	cmd_t  back_cmd;
	logic  cmd_empty;
	logic  cmd_pop;
	out_t  result;

	assign take = push && !full;

	// Front: classifies requests and owns the logger state.
	etl_front #(
		.BANK_BYTES (BANK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.req_type    (req_type),
		.pin_level   (pin_level),
		.timer_count (timer_count),
		.byte_index  (byte_index),
		.cmd         (front_cmd)
	);

	// Command queue between front and back.
	etl_fifo #(
		.T     (cmd_t),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (back_cmd),
		.empty  (cmd_empty),
		.level  ()
	);

	// Back: byte memories and result queue.
	etl_back #(
		.BANK_BYTES (BANK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign accepted   = result.res.accepted;
	assign dropped    = result.res.dropped;
	assign bank       = result.res.bank;
	assign frozen_len = result.res.frozen_len;
	assign byte_data  = result.byte_data;
	assign edge_count = result.res.edge_count;

endmodule

>>> tb/sv/logger_shadow_pkg.sv
`timescale 1ns / 100ps
package logger_shadow_pkg;
	import etl_pkg::*;

	localparam int BANK_BYTES = 512;

	// Request codes that the block ignores.
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	// Mismatches beyond this count are only tallied.
	localparam int REPORT_LIMIT = 10;

	// Shadow copy of the logger state plus the queue of result beats it predicts.
	class logger_shadow;
		logic [7:0]  byte_mem [2*BANK_BYTES];
		int unsigned fill [2];
		bit          active;
		bit          run_open;
		logic [5:0]  run_byte;
		bit          logging;
		logic [15:0] high_edges;
		out_t        expected_beats [$];
		int unsigned mismatches;

		function new();
			foreach (byte_mem[i]) byte_mem[i] = '0;
			fill[0] = 0;
			fill[1] = 0;
			active = 0;
			run_open = 0;
			run_byte = '0;
			logging = 0;
			high_edges = '0;
			mismatches = 0;
		endfunction

		function int unsigned active_fill();
			return fill[active];
		endfunction

		function int unsigned handed_fill();
			return fill[!active];
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function string show(out_t b);
			return $sformatf("acc=%0d drop=%0d bank=%0d len=%0d data=%02h cnt=%04h",
				b.res.accepted, b.res.dropped, b.res.bank, b.res.frozen_len,
				b.byte_data, b.res.edge_count);
		endfunction

		// Apply one accepted request to the shadow state and queue its result beat.
		function void note_request(logic [2:0] req, logic pin, logic [13:0] tc,
				logic [8:0] idx);
			out_t        r;
			logic [15:0] word;
			int unsigned f;
			int unsigned base;
			int unsigned other_base;
			r = '0;
			f = fill[active];
			base = active ? BANK_BYTES : 0;
			other_base = active ? 0 : BANK_BYTES;
			case (req)
				REQ_START: begin
					fill[0] = 0;
					fill[1] = 0;
					active = 0;
					run_open = 0;
					run_byte = '0;
					high_edges = '0;
					logging = 1;
					r.res.accepted = 1'b1;
				end
				REQ_STOP: begin
					logging = 0;
					r.res.accepted = 1'b1;
				end
				REQ_EDGE: begin
					if (logging) begin
						// An edge word needs two free bytes, otherwise it is lost.
						if (f + 2 <= BANK_BYTES) begin
							word = {2'b00, tc} | (pin ? MARK_HIGH : MARK_LOW);
							byte_mem[base + f] = word[15:8];
							byte_mem[base + f + 1] = word[7:0];
							fill[active] = f + 2;
							run_open = 0;
							r.res.accepted = 1'b1;
						end else begin
							r.res.dropped = 1'b1;
						end
						if (pin)
							high_edges = high_edges + 16'd1;
					end
				end
				REQ_TICK: begin
					if (logging) begin
						// An open run grows in place until it reaches its ceiling.
						if (run_open && run_byte <= RUN_LIMIT && f > 0) begin
							run_byte = run_byte + 6'd1;
							byte_mem[base + f - 1] = {2'b00, run_byte};
							r.res.accepted = 1'b1;
						end else if (f < BANK_BYTES) begin
							byte_mem[base + f] = 8'd1;
							fill[active] = f + 1;
							run_open = 1;
							run_byte = 6'd1;
							r.res.accepted = 1'b1;
						end else begin
							r.res.dropped = 1'b1;
						end
					end
				end
				REQ_SWAP: begin
					// An empty bank is never handed over.
					if (f != 0) begin
						r.res.bank = active;
						r.res.frozen_len = 10'(f);
						active = !active;
						fill[active] = 0;
						run_open = 0;
						r.res.accepted = 1'b1;
					end
				end
				REQ_READ: begin
					if (idx < fill[!active]) begin
						r.byte_data = byte_mem[other_base + idx];
						r.res.accepted = 1'b1;
					end
				end
				default: begin
				end
			endcase
			r.res.edge_count = high_edges;
			expected_beats.push_back(r);
		endfunction

		// Compare one result beat with the oldest prediction.
		function void check_result(out_t got);
			out_t exp;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t mismatch: result beat with nothing expected, actual %s",
						$time, show(got));
				return;
			end
			exp = expected_beats.pop_front();
			if (got.res.accepted !== exp.res.accepted ||
					got.res.dropped !== exp.res.dropped ||
					got.res.bank !== exp.res.bank ||
					got.res.frozen_len !== exp.res.frozen_len ||
					got.byte_data !== exp.byte_data ||
					got.res.edge_count !== exp.res.edge_count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t mismatch: expected %s, actual %s",
						$time, show(exp), show(got));
			end
		endfunction
	endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import etl_pkg::*;
	import logger_shadow_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int ITEM_TARGET    = 900;
	localparam int QUIET_AFTER    = 780;
	localparam int LONG_HOLD      = 150;
	localparam int SETTLE_CYCLES  = 20;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int FILL_ITEMS_MAX = 400;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  req_type;
	logic        pin_level;
	logic [13:0] timer_count;
	logic [8:0]  byte_index;
	logic        empty;
	logic        pop;
	logic        accepted;
	logic        dropped;
	logic        bank;
	logic [9:0]  frozen_len;
	logic [7:0]  byte_data;
	logic [15:0] edge_count;

	logger_shadow shadow;
	int unsigned  items_sent;
	int unsigned  cycles = 0;
	int unsigned  hold_left;
	int unsigned  stall_left;
	bit           quiet;
	int unsigned  hold_asks = 0;
	int unsigned  hold_seen;

	edge_timestamp_pingpong_logger_top #(
		.BANK_BYTES(BANK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.pin_level(pin_level),
		.timer_count(timer_count),
		.byte_index(byte_index),
		.empty(empty),
		.pop(pop),
		.accepted(accepted),
		.dropped(dropped),
		.bank(bank),
		.frozen_len(frozen_len),
		.byte_data(byte_data),
		.edge_count(edge_count)
	);

	always #(CLK_HALF) clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one request beat, with an optional random gap first, and wait for it to be taken.
	task automatic send_item(input logic [2:0] req, input logic pin, input logic [13:0] tc,
			input logic [8:0] idx);
		if (items_sent >= QUIET_AFTER)
			quiet = 1;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= req;
		pin_level <= pin;
		timer_count <= tc;
		byte_index <= idx;
		do @(posedge clk); while (full);
		shadow.note_request(req, pin, tc, idx);
		if (req != REQ_RSVD6 && req != REQ_RSVD7)
			items_sent++;
	endtask

	// Request with every other field random.
	task automatic send_simple(input logic [2:0] req);
		send_item(req, 1'($urandom_range(0, 1)), 14'($urandom_range(0, 16383)),
			9'($urandom_range(0, 511)));
	endtask

	task automatic send_read(input logic [8:0] idx);
		send_item(REQ_READ, 1'($urandom_range(0, 1)), 14'($urandom_range(0, 16383)), idx);
	endtask

	// Reads mostly land inside the handed-over bank, a few at or past its end.
	task automatic read_back(input int unsigned count);
		int unsigned hf;
		int unsigned r;
		logic [8:0]  idx;
		repeat (count) begin
			hf = shadow.handed_fill();
			r = $urandom_range(0, 19);
			if (hf > 0 && r < 17)
				idx = 9'($urandom_range(0, hf - 1));
			else if (r == 17 && hf < BANK_BYTES)
				idx = 9'(hf);
			else
				idx = 9'($urandom_range(0, 511));
			send_read(idx);
		end
	endtask

	// Stop offering beats until every predicted result has come out.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// A short logging session: events, maybe a stop, usually a swap, then read-back.
	task automatic normal_session();
		int unsigned n;
		if ($urandom_range(0, 7) != 0)
			send_simple(REQ_START);
		n = $urandom_range(1, 40);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				send_simple(3'($urandom_range(0, 7)));
			else if ($urandom_range(0, 99) < 55)
				send_simple(REQ_EDGE);
			else
				send_simple(REQ_TICK);
		end
		// A long run of ticks walks the run byte up to its ceiling and past it.
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(58, 70)) send_simple(REQ_TICK);
		// Events after a stop must be ignored.
		if ($urandom_range(0, 3) == 0) begin
			send_simple(REQ_STOP);
			repeat ($urandom_range(1, 3))
				send_simple($urandom_range(0, 1) ? REQ_EDGE : REQ_TICK);
		end
		if ($urandom_range(0, 9) != 0)
			send_simple(REQ_SWAP);
		read_back($urandom_range(1, 20));
		if ($urandom_range(0, 4) == 0)
			send_simple(REQ_SWAP);
	endtask

	// Fill a bank to the brim, then hit it with ticks and with edges that find no room.
	task automatic fill_session();
		send_simple(REQ_START);
		while (shadow.active_fill() < BANK_BYTES - 1)
			send_simple(($urandom_range(0, 9) == 0) ? REQ_TICK : REQ_EDGE);
		repeat ($urandom_range(60, 72)) send_simple(REQ_TICK);
		repeat ($urandom_range(2, 5)) send_simple(REQ_EDGE);
		send_simple(REQ_SWAP);
		send_read(9'd0);
		send_read(9'(shadow.handed_fill() - 1));
		send_read(9'h1FF);
		read_back($urandom_range(5, 20));
	endtask

	// Result side: check each popped beat, then choose pop for the next cycle.
	initial begin
		pop = 1'b0;
		hold_left = 0;
		stall_left = 0;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			// Field order follows the packed result beat type.
			if (pop && !empty)
				shadow.check_result({accepted, dropped, bank, frozen_len, edge_count,
					byte_data});
			if (hold_seen != hold_asks) begin
				hold_left = LONG_HOLD;
				hold_seen = hold_asks;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Request side: reset, directed beats, random sessions, then the final verdict.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		req_type = REQ_START;
		pin_level = 1'b0;
		timer_count = '0;
		byte_index = '0;
		quiet = 0;
		items_sent = 0;
		shadow = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing handed over yet, empty swap, events while not logging, unknown codes.
		send_read(9'd0);
		send_simple(REQ_SWAP);
		send_item(REQ_EDGE, 1'b1, 14'h3FFF, 9'd0);
		send_simple(REQ_TICK);
		send_simple(REQ_RSVD6);
		send_simple(REQ_RSVD7);

		// Edge words at the extremes of the timer and both levels.
		send_simple(REQ_START);
		send_item(REQ_EDGE, 1'b1, 14'h3FFF, 9'h1FF);
		send_item(REQ_EDGE, 1'b0, 14'h0000, 9'd0);
		send_item(REQ_EDGE, 1'b1, 14'h0000, 9'd0);
		send_item(REQ_EDGE, 1'b0, 14'h3FFF, 9'd0);

		// A tick opens a run, the next one grows it, an edge closes it.
		send_simple(REQ_TICK);
		send_simple(REQ_TICK);
		send_simple(REQ_EDGE);
		send_simple(REQ_TICK);

		// Stop, ignored events, and a swap that still works with logging off.
		send_simple(REQ_STOP);
		send_simple(REQ_EDGE);
		send_simple(REQ_TICK);
		send_simple(REQ_SWAP);

		// Reads inside, at the end of and past the handed-over bank.
		send_read(9'd0);
		send_read(9'(shadow.handed_fill() - 1));
		send_read(9'(shadow.handed_fill()));
		send_read(9'h1FF);
		send_simple(REQ_SWAP);
		wait_drained();

		// The first random session runs into a long hold-off on the result side.
		hold_asks++;
		fill_session();
		wait_drained();
		while (items_sent < ITEM_TARGET) begin
			if (!quiet && $urandom_range(0, 9) == 0)
				hold_asks++;
			// A full bank session is long, so it only runs while there is room for it.
			if (items_sent + FILL_ITEMS_MAX < ITEM_TARGET && $urandom_range(0, 11) == 0)
				fill_session();
			else
				normal_session();
			if (!quiet && $urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
